/* src/gpfa_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gpfa_pkg;

	localparam int NUM_DEVICES = 64;
	localparam int DEV_W = 6;
	localparam int DEV_CNT_W = 7;
	localparam int SLOTS = 7;
	localparam int SLOT_W = 3;
	localparam int OWNER_W = 8;
	localparam int SIZE_W = 3;
	localparam int STATUS_W = 3;
	localparam int REC_AW = DEV_W + SLOT_W;
	localparam int REC_DEPTH = 1 << REC_AW;
	localparam int DEV_EN_RESET = 64;

	localparam logic [SLOT_W-1:0] NO_SLOT = 3'd7;
	localparam logic [SIZE_W-1:0] FULL_USAGE = 3'd7;

	localparam logic [SIZE_W-1:0] SIZE_1 = 3'd1;
	localparam logic [SIZE_W-1:0] SIZE_2 = 3'd2;
	localparam logic [SIZE_W-1:0] SIZE_3 = 3'd3;
	localparam logic [SIZE_W-1:0] SIZE_4 = 3'd4;
	localparam logic [SIZE_W-1:0] SIZE_7 = 3'd7;

	localparam logic [SLOT_W-1:0] SLOT_LOW = 3'd0;
	localparam logic [SLOT_W-1:0] SLOT_MID = 3'd4;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [SLOT_W-1:0] PRIO2 [3] = '{3'd0, 3'd4, 3'd2};
	localparam logic [SLOT_W-1:0] PRIO1 [7] = '{3'd0, 3'd6, 3'd4, 3'd1, 3'd2, 3'd3, 3'd5};

	typedef enum logic [STATUS_W-1:0] {
		ST_OK         = 3'd0,
		ST_NO_DEVICE  = 3'd1,
		ST_NO_SLOT    = 3'd2,
		ST_BAD_SIZE   = 3'd3,
		ST_SLOT_EMPTY = 3'd4
	} gpfa_status_t;

	typedef enum logic [2:0] {
		GS_IDLE,
		GS_RELEASE,
		GS_SCAN,
		GS_PICK,
		GS_DONE
	} gpfa_state_t;

	// one row of per-device state
	typedef struct packed {
		logic [SLOTS-1:0]  occ;
		logic              s3_low;
		logic              s3_mid;
		logic [SIZE_W-1:0] usage;
	} gpfa_row_t;

	typedef struct packed {
		logic [OWNER_W-1:0] owner;
		logic [SIZE_W-1:0]  size;
	} gpfa_rec_t;

	function automatic logic size_ok(input logic [SIZE_W-1:0] size);
		return (size == SIZE_1) || (size == SIZE_2) || (size == SIZE_3) ||
			(size == SIZE_4) || (size == SIZE_7);
	endfunction

	// first free start slot in priority order, NO_SLOT when none
	function automatic logic [SLOT_W-1:0] pick_slot(input logic [SLOTS-1:0] occ,
		input logic [SIZE_W-1:0] size);
		logic [SLOT_W-1:0] s;
		int i;
		s = NO_SLOT;
		case (size)
			SIZE_7, SIZE_4: begin
				if (!occ[SLOT_LOW])
					s = SLOT_LOW;
			end
			SIZE_3: begin
				if (!occ[SLOT_MID])
					s = SLOT_MID;
			end
			SIZE_2: begin
				for (i = 2; i >= 0; i--)
					if (!occ[PRIO2[i]])
						s = PRIO2[i];
			end
			SIZE_1: begin
				for (i = 6; i >= 0; i--)
					if (!occ[PRIO1[i]])
						s = PRIO1[i];
			end
			default: s = NO_SLOT;
		endcase
		return s;
	endfunction

endpackage
`default_nettype wire

/* src/gpfa_if.sv */
`timescale 1ns / 1ps
`default_nettype none
interface gpfa_req_if;
	logic                             valid;
	logic                             ready;
	logic                             mode;
	logic [gpfa_pkg::SIZE_W-1:0]      request_size;
	logic [gpfa_pkg::OWNER_W-1:0]     owner_id;
	logic [gpfa_pkg::DEV_W-1:0]       device_sel;
	logic [gpfa_pkg::SLOT_W-1:0]      slot_sel;

	modport source (output valid, mode, request_size, owner_id, device_sel, slot_sel,
		input ready);
	modport sink (input valid, mode, request_size, owner_id, device_sel, slot_sel,
		output ready);
endinterface

interface gpfa_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [gpfa_pkg::STATUS_W-1:0]    status;
	logic [gpfa_pkg::DEV_W-1:0]       device_out;
	logic [gpfa_pkg::SLOT_W-1:0]      slot_out;
	logic [gpfa_pkg::SIZE_W-1:0]      freed_size;
	logic [gpfa_pkg::OWNER_W-1:0]     freed_owner;

	modport source (output valid, status, device_out, slot_out, freed_size, freed_owner,
		input ready);
	modport sink (input valid, status, device_out, slot_out, freed_size, freed_owner,
		output ready);
endinterface
`default_nettype wire

/* src/gpu_partition_best_fit_allocator.sv */
// allocate: scans n device rows, n = min(devices_enabled, 64), then picks a slot;
//   the scan reads one device row per cycle from the row memory
// release: one row and one record memory read, then write-back
// bad size or nothing enabled: result without a scan; one request in flight at a time
// reset clears the 64 row-valid flops at once, no clearing pass; an unwritten
//   row reads as empty, slot records are only read behind a set occupancy bit
`timescale 1ns / 1ps
`default_nettype none
module gpu_partition_best_fit_allocator (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              cfg_we,
	input  wire [gpfa_pkg::DEV_CNT_W-1:0]    cfg_wdata,
	gpfa_req_if.sink                         req,
	gpfa_rsp_if.source                       rsp
);

	gpfa_pkg::gpfa_state_t state_q, state_d;

	// config
	logic [gpfa_pkg::DEV_CNT_W-1:0] dev_en_q;
	logic [gpfa_pkg::DEV_CNT_W-1:0] n_lim;

	// latched request
	logic [gpfa_pkg::SIZE_W-1:0]   size_q;
	logic [gpfa_pkg::OWNER_W-1:0]  owner_q;
	logic [gpfa_pkg::DEV_W-1:0]    dsel_q;
	logic [gpfa_pkg::SLOT_W-1:0]   ssel_q;

	// memories
	gpfa_pkg::gpfa_row_t row_mem [gpfa_pkg::NUM_DEVICES];
	gpfa_pkg::gpfa_rec_t rec_mem [gpfa_pkg::REC_DEPTH];
	logic [gpfa_pkg::NUM_DEVICES-1:0] row_vld_q;

	logic [gpfa_pkg::DEV_W-1:0]    row_raddr;
	gpfa_pkg::gpfa_row_t           rd_row_s1;
	logic                          rd_ok_s1;
	gpfa_pkg::gpfa_row_t           row_rd;
	logic                          row_we;
	logic [gpfa_pkg::DEV_W-1:0]    row_waddr;
	gpfa_pkg::gpfa_row_t           row_wdata;

	logic [gpfa_pkg::REC_AW-1:0]   rec_raddr;
	gpfa_pkg::gpfa_rec_t           rec_rd_s1;
	logic                          rec_we;
	logic [gpfa_pkg::REC_AW-1:0]   rec_waddr;
	gpfa_pkg::gpfa_rec_t           rec_wdata;

	// scan
	logic [gpfa_pkg::DEV_CNT_W-1:0] scan_q;
	logic                           issue_s1;
	logic [gpfa_pkg::DEV_W-1:0]     idx_s1;
	logic [gpfa_pkg::DEV_W-1:0]     best_q;
	logic [3:0]                     best_diff_q;
	logic                           found_q;
	gpfa_pkg::gpfa_row_t            best_row_q;
	logic [gpfa_pkg::SIZE_W-1:0]    empty_sl;
	logic [gpfa_pkg::SIZE_W-1:0]    diff_sl;
	logic                           cand_ok;

	logic [gpfa_pkg::SLOT_W-1:0]    pick;
	logic [gpfa_pkg::SIZE_W-1:0]    rel_usage;

	// result
	logic                           res_load;
	gpfa_pkg::gpfa_status_t         res_status_d, res_status_q;
	logic [gpfa_pkg::DEV_W-1:0]     res_dev_d, res_dev_q;
	logic [gpfa_pkg::SLOT_W-1:0]    res_slot_d, res_slot_q;
	logic [gpfa_pkg::SIZE_W-1:0]    res_fsize_d, res_fsize_q;
	logic [gpfa_pkg::OWNER_W-1:0]   res_fowner_d, res_fowner_q;

	logic                           out_vld_q;
	logic                           out_load;
	logic                           req_xfer;

	assign req_xfer = req.valid && req.ready;
	assign req.ready = (state_q == gpfa_pkg::GS_IDLE);

	assign n_lim = (dev_en_q > gpfa_pkg::DEV_CNT_W'(gpfa_pkg::NUM_DEVICES)) ?
		gpfa_pkg::DEV_CNT_W'(gpfa_pkg::NUM_DEVICES) : dev_en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_en_q <= gpfa_pkg::DEV_CNT_W'(gpfa_pkg::DEV_EN_RESET);
		end else if (cfg_we) begin
			dev_en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req_xfer) begin
			size_q  <= req.request_size;
			owner_q <= req.owner_id;
			dsel_q  <= req.device_sel;
			ssel_q  <= req.slot_sel;
		end
	end

	// row memory, a never written row reads as all zero
	always_ff @(posedge clk) begin
		if (row_we)
			row_mem[row_waddr] <= row_wdata;
		rd_row_s1 <= row_mem[row_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_ok_s1  <= 1'b0;
		end else begin
			if (row_we)
				row_vld_q[row_waddr] <= 1'b1;
			rd_ok_s1 <= row_vld_q[row_raddr];
		end
	end

	assign row_rd = rd_ok_s1 ? rd_row_s1 : '0;

	always_ff @(posedge clk) begin
		if (rec_we)
			rec_mem[rec_waddr] <= rec_wdata;
		rec_rd_s1 <= rec_mem[rec_raddr];
	end

	// best-fit candidate test on the row read last cycle
	always_comb begin
		empty_sl = gpfa_pkg::FULL_USAGE - row_rd.usage;
		diff_sl  = empty_sl - size_q;
		cand_ok  = (empty_sl >= size_q) && ({1'b0, diff_sl} < best_diff_q) &&
			!((size_q == gpfa_pkg::SIZE_3) && row_rd.s3_mid) &&
			!((size_q == gpfa_pkg::SIZE_1) && row_rd.s3_low && row_rd.s3_mid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q      <= '0;
			issue_s1    <= 1'b0;
			found_q     <= 1'b0;
			best_diff_q <= 4'd8;
		end else begin
			issue_s1 <= (state_q == gpfa_pkg::GS_SCAN) && (scan_q != n_lim);
			if (state_q == gpfa_pkg::GS_IDLE) begin
				scan_q      <= '0;
				found_q     <= 1'b0;
				best_diff_q <= 4'd8;
			end else begin
				if ((state_q == gpfa_pkg::GS_SCAN) && (scan_q != n_lim))
					scan_q <= scan_q + 1'b1;
				if (issue_s1 && cand_ok) begin
					found_q     <= 1'b1;
					best_diff_q <= {1'b0, diff_sl};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= scan_q[gpfa_pkg::DEV_W-1:0];
		if (issue_s1 && cand_ok) begin
			best_q     <= idx_s1;
			best_row_q <= row_rd;
		end
	end

	assign pick = gpfa_pkg::pick_slot(best_row_q.occ, size_q);
	assign rel_usage = (row_rd.usage >= rec_rd_s1.size) ?
		row_rd.usage - rec_rd_s1.size : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gpfa_pkg::GS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		row_raddr    = scan_q[gpfa_pkg::DEV_W-1:0];
		rec_raddr    = {req.device_sel, req.slot_sel};
		row_we       = 1'b0;
		row_waddr    = dsel_q;
		row_wdata    = row_rd;
		rec_we       = 1'b0;
		rec_waddr    = {best_q, pick};
		rec_wdata    = '{owner: owner_q, size: size_q};
		res_load     = 1'b0;
		res_status_d = gpfa_pkg::ST_OK;
		res_dev_d    = '0;
		res_slot_d   = '0;
		res_fsize_d  = '0;
		res_fowner_d = '0;
		out_load     = 1'b0;
		case (state_q)
			gpfa_pkg::GS_IDLE: begin
				row_raddr = req.device_sel;
				if (req.valid) begin
					if (req.mode == gpfa_pkg::MODE_RELEASE) begin
						if (req.slot_sel == gpfa_pkg::NO_SLOT) begin
							res_load     = 1'b1;
							res_status_d = gpfa_pkg::ST_SLOT_EMPTY;
							res_dev_d    = req.device_sel;
							res_slot_d   = req.slot_sel;
							state_d      = gpfa_pkg::GS_DONE;
						end else begin
							state_d = gpfa_pkg::GS_RELEASE;
						end
					end else if (!gpfa_pkg::size_ok(req.request_size)) begin
						res_load     = 1'b1;
						res_status_d = gpfa_pkg::ST_BAD_SIZE;
						state_d      = gpfa_pkg::GS_DONE;
					end else if (n_lim == '0) begin
						res_load     = 1'b1;
						res_status_d = gpfa_pkg::ST_NO_DEVICE;
						state_d      = gpfa_pkg::GS_DONE;
					end else begin
						state_d = gpfa_pkg::GS_SCAN;
					end
				end
			end
			gpfa_pkg::GS_RELEASE: begin
				res_load   = 1'b1;
				res_dev_d  = dsel_q;
				res_slot_d = ssel_q;
				if (row_rd.occ[ssel_q]) begin
					res_fsize_d  = rec_rd_s1.size;
					res_fowner_d = rec_rd_s1.owner;
					row_we       = 1'b1;
					row_wdata.occ[ssel_q] = 1'b0;
					row_wdata.usage = rel_usage;
					if (ssel_q == gpfa_pkg::SLOT_LOW)
						row_wdata.s3_low = 1'b0;
					if (ssel_q == gpfa_pkg::SLOT_MID)
						row_wdata.s3_mid = 1'b0;
				end else begin
					res_status_d = gpfa_pkg::ST_SLOT_EMPTY;
				end
				state_d = gpfa_pkg::GS_DONE;
			end
			gpfa_pkg::GS_SCAN: begin
				if ((scan_q == n_lim) && !issue_s1)
					state_d = gpfa_pkg::GS_PICK;
			end
			gpfa_pkg::GS_PICK: begin
				res_load = 1'b1;
				if (!found_q) begin
					res_status_d = gpfa_pkg::ST_NO_DEVICE;
				end else if (pick == gpfa_pkg::NO_SLOT) begin
					res_status_d = gpfa_pkg::ST_NO_SLOT;
					res_dev_d    = best_q;
				end else begin
					res_dev_d  = best_q;
					res_slot_d = pick;
					row_we     = 1'b1;
					row_waddr  = best_q;
					row_wdata  = best_row_q;
					row_wdata.occ[pick] = 1'b1;
					row_wdata.usage = best_row_q.usage + size_q;
					if (size_q == gpfa_pkg::SIZE_3 && pick == gpfa_pkg::SLOT_LOW)
						row_wdata.s3_low = 1'b1;
					if (size_q == gpfa_pkg::SIZE_3 && pick == gpfa_pkg::SLOT_MID)
						row_wdata.s3_mid = 1'b1;
					rec_we = 1'b1;
				end
				state_d = gpfa_pkg::GS_DONE;
			end
			gpfa_pkg::GS_DONE: begin
				// wait for the output register to free up
				if (!out_vld_q || rsp.ready) begin
					out_load = 1'b1;
					state_d  = gpfa_pkg::GS_IDLE;
				end
			end
			default: begin
				state_d = gpfa_pkg::GS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_status_q <= res_status_d;
			res_dev_q    <= res_dev_d;
			res_slot_q   <= res_slot_d;
			res_fsize_q  <= res_fsize_d;
			res_fowner_q <= res_fowner_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rsp.status      <= res_status_q;
			rsp.device_out  <= res_dev_q;
			rsp.slot_out    <= res_slot_q;
			rsp.freed_size  <= res_fsize_q;
			rsp.freed_owner <= res_fowner_q;
		end
	end

	assign rsp.valid = out_vld_q;

	a_no_write_on_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		(row_we || rec_we) |-> !req_xfer)
		else $error("memory write while a request transfers");

	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		req_xfer |=> !req.ready)
		else $error("request taken while previous one still in work");

	a_best_diff_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gpfa_pkg::GS_PICK && found_q) |-> (best_diff_q <= 4'd6))
		else $error("best fit recorded without a fitting device");

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> (({1'b0, best_row_q.usage} + {1'b0, size_q}) <= 4'd7))
		else $error("allocation overfills a device");

endmodule
`default_nettype wire
